// ===== src/clbgr_pkg.sv =====
package clbgr_pkg;

  localparam int unsigned SlotW = 3;
  localparam int unsigned ColW  = 6;
  localparam int unsigned RowW  = 2;
  localparam int unsigned LenW  = 5;
  localparam int unsigned PctW  = 18;
  localparam int unsigned CntW  = 10;   // signed fill count, -153..306
  localparam int unsigned ProdW = 22;   // (5*len-2)*|p| < 2^22
  localparam int unsigned QuoW  = 9;    // |count| <= 306

  localparam logic [1:0] CFG_START  = 2'd0;
  localparam logic [1:0] CFG_MIDDLE = 2'd1;
  localparam logic [1:0] CFG_END    = 2'd2;

  localparam logic signed [PctW-1:0] P_MIN = -18'sd10000;
  localparam logic signed [PctW-1:0] P_MAX = 18'sd20000;
  // ceil(2^34 / 10000); exact quotient for any product below 2^22
  localparam logic [20:0] DIV_RECIP = 21'd1717987;
  localparam int unsigned DIV_SHIFT = 34;
  localparam logic [7:0] FULL_BLOCK = 8'hFF;

  localparam logic [39:0] G_SINGLE = {5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F};
  localparam logic [39:0] G_START  = {5'h1F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
  localparam logic [39:0] G_END    = {5'h1F, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h1F};
  localparam logic [39:0] G_MIDDLE = {5'h1F, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
  localparam logic [39:0] G_OVER   = {5'h1F, 5'h0B, 5'h15, 5'h1A, 5'h1A, 5'h15, 5'h0B, 5'h1F};
  localparam logic [39:0] G_UNDER  = {5'h00, 5'h05, 5'h0A, 5'h14, 5'h14, 5'h0A, 5'h05, 5'h00};

  typedef struct packed {
    logic [SlotW-1:0] start_slot;
    logic [SlotW-1:0] middle_slot;
    logic [SlotW-1:0] end_slot;
  } cfg_t;

  // one classified bar, handed from front to back
  typedef struct packed {
    logic [SlotW-1:0]       slot;
    logic [ColW-1:0]        col;
    logic [RowW-1:0]        row;
    logic [LenW-1:0]        len;
    logic signed [CntW-1:0] cnt;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_PUSH
  } front_state_e;

endpackage

// ===== src/clbgr_front.sv =====
module clbgr_front import clbgr_pkg::*; #(
  parameter int unsigned MAX_CELLS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SlotW-1:0]       glyph_slot_i,
  input  logic [ColW-1:0]        pos_col_i,
  input  logic [RowW-1:0]        pos_row_i,
  input  logic [LenW-1:0]        bar_length_i,
  input  logic signed [PctW-1:0] percent_hundredths_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output job_t                   push_job_o
);

  localparam logic [6:0] MaxCells = 7'(MAX_CELLS);

  front_state_e state_q, state_d;

  logic [SlotW-1:0] slot_q;
  logic [ColW-1:0]  col_q;
  logic [RowW-1:0]  row_q;
  logic [LenW-1:0]  len_q;
  logic [14:0]      mag_q;
  logic             neg_q;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [QuoW-1:0]  quo_q, quo_d;

  logic [LenW-1:0]        len_sat;
  logic signed [PctW-1:0] p_clamp;
  logic [15:0]            p16;
  logic [15:0]            p_abs;
  logic [7:0]             mul_len;
  logic [22:0]            prod;
  logic [ProdW+20:0]      recip_prod;
  logic                   accept;
  logic signed [CntW-1:0] quo_s;

  assign len_sat = ({2'b0, bar_length_i} > MaxCells) ? MaxCells[LenW-1:0] : bar_length_i;

  always_comb begin
    if (percent_hundredths_i < P_MIN) begin
      p_clamp = P_MIN;
    end else if (percent_hundredths_i > P_MAX) begin
      p_clamp = P_MAX;
    end else begin
      p_clamp = percent_hundredths_i;
    end
  end

  assign p16   = p_clamp[15:0];
  assign p_abs = p16[15] ? (16'd0 - p16) : p16;

  assign mul_len = ({3'b0, len_q} << 2) + {3'b0, len_q} - 8'd2;
  assign prod    = mul_len * mag_q;

  // divide by 10000 as a multiply by the scaled reciprocal
  assign recip_prod = prod_q * DIV_RECIP;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    prod_d       = prod_q;
    quo_d        = quo_q;
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (len_sat != '0)) begin
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        prod_d  = prod[ProdW-1:0];
        state_d = F_DIV;
      end
      F_DIV: begin
        quo_d   = recip_prod[DIV_SHIFT +: QuoW];
        state_d = F_PUSH;
      end
      F_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    quo_q  <= quo_d;
    if (accept) begin
      slot_q <= glyph_slot_i;
      col_q  <= pos_col_i;
      row_q  <= pos_row_i;
      len_q  <= len_sat;
      mag_q  <= p_abs[14:0];
      neg_q  <= p16[15];
    end
  end

  assign quo_s = $signed({1'b0, quo_q});

  always_comb begin
    push_job_o.slot = slot_q;
    push_job_o.col  = col_q;
    push_job_o.row  = row_q;
    push_job_o.len  = len_q;
    push_job_o.cnt  = neg_q ? -quo_s : quo_s;
  end

endmodule

// ===== src/clbgr_queue.sv =====
module clbgr_queue import clbgr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== src/clbgr_back.sv =====
module clbgr_back import clbgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        empty_i,
  input  job_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  cell_column_o,
  output logic [1:0]  cell_row_o,
  output logic [7:0]  char_code_o,
  output logic        define_glyph_o,
  output logic [39:0] glyph_bits_o,
  output logic        last_cell_o
);

  logic                   busy_q;
  job_t                   job_q;
  logic [LenW-1:0]        idx_q;
  logic signed [CntW-1:0] cnt_q;
  logic                   out_valid_q;

  logic                   advance;
  logic                   first, last;
  logic [2:0]             cap;
  logic signed [CntW-1:0] cap_s, cnt_sub, cnt_nxt;
  logic [7:0]             code;
  logic                   def;
  logic [39:0]            bits, base;
  logic [4:0]             mask;

  assign advance = !out_valid_q || out_ready_i;
  assign pop_o   = !busy_q && !empty_i;

  assign first   = (idx_q == '0);
  assign last    = (idx_q == job_q.len - 5'd1);
  assign cap     = 3'd5 - {2'b0, first} - {2'b0, last};
  assign cap_s   = $signed({7'b0, cap});
  assign cnt_sub = cnt_q - cap_s;

  always_comb begin
    if (first && last) begin
      base = G_SINGLE;
    end else if (first) begin
      base = G_START;
    end else if (last) begin
      base = G_END;
    end else begin
      base = G_MIDDLE;
    end
    // leftmost cnt dot columns, moved right past the start frame column
    mask = (~(5'h1F >> cnt_q[2:0])) >> first;
  end

  always_comb begin
    code    = {5'b0, job_q.slot};
    def     = 1'b1;
    bits    = '0;
    cnt_nxt = cnt_q;
    if (cnt_q == '0) begin
      if (first && last) begin
        bits = G_SINGLE;
      end else begin
        def = 1'b0;
        if (first) begin
          code = {5'b0, cfg_i.start_slot};
        end else if (last) begin
          code = {5'b0, cfg_i.end_slot};
        end else begin
          code = {5'b0, cfg_i.middle_slot};
        end
      end
    end else if (cnt_q >= cap_s) begin
      cnt_nxt = cnt_sub;
      if ((cnt_sub > 0) && last) begin
        bits = G_OVER;
      end else begin
        def  = 1'b0;
        code = FULL_BLOCK;
      end
    end else if ((cnt_q < 0) && first) begin
      cnt_nxt = '0;
      bits    = G_UNDER;
    end else begin
      cnt_nxt = '0;
      bits    = base | {5'b0, {6{mask}}, 5'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (busy_q && advance && last) begin
        busy_q <= 1'b0;
      end
      if (busy_q && advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
      idx_q <= '0;
      cnt_q <= head_i.cnt;
    end else if (busy_q && advance) begin
      idx_q <= idx_q + 5'd1;
      cnt_q <= cnt_nxt;
    end
    if (busy_q && advance) begin
      cell_column_o  <= {1'b0, job_q.col} + {2'b0, idx_q};
      cell_row_o     <= job_q.row;
      char_code_o    <= code;
      define_glyph_o <= def;
      glyph_bits_o   <= bits;
      last_cell_o    <= last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/char_lcd_bar_graph_renderer.sv =====
// Bar-graph renderer for a 5x8-dot character display. Each accepted draw
// request yields one output beat per character cell, left to right; a
// request with zero length yields nothing. The front end takes each request
// through input register, one multiply, a reciprocal multiply for the divide
// by 10000 and hand-off, and takes no new request until the last is handed
// off; the back end then emits one cell per cycle while the output is not
// stalled. A two-entry queue lets the two overlap.
// Slot registers are written through the cfg port and must only change while
// idle.
module char_lcd_bar_graph_renderer import clbgr_pkg::*; #(
  parameter int unsigned MAX_CELLS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [SlotW-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SlotW-1:0]       glyph_slot_i,
  input  logic [ColW-1:0]        pos_col_i,
  input  logic [RowW-1:0]        pos_row_i,
  input  logic [LenW-1:0]        bar_length_i,
  input  logic signed [PctW-1:0] percent_hundredths_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [6:0]             cell_column_o,
  output logic [1:0]             cell_row_o,
  output logic [7:0]             char_code_o,
  output logic                   define_glyph_o,
  output logic [39:0]            glyph_bits_o,
  output logic                   last_cell_o
);

  cfg_t cfg_q;
  logic push_valid, full, empty, pop;
  job_t push_job, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_slot  <= 3'd0;
      cfg_q.middle_slot <= 3'd1;
      cfg_q.end_slot    <= 3'd2;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_START) begin
        cfg_q.start_slot <= cfg_data_i;
      end else if (cfg_idx_i == CFG_MIDDLE) begin
        cfg_q.middle_slot <= cfg_data_i;
      end else if (cfg_idx_i == CFG_END) begin
        cfg_q.end_slot <= cfg_data_i;
      end
    end
  end

  clbgr_front #(
    .MAX_CELLS(MAX_CELLS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .glyph_slot_i,
    .pos_col_i,
    .pos_row_i,
    .bar_length_i,
    .percent_hundredths_i,
    .push_valid_o(push_valid),
    .push_ready_i(!full),
    .push_job_o  (push_job)
  );

  clbgr_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i    (push_valid),
    .push_job_i(push_job),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .head_o    (head)
  );

  clbgr_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i  (cfg_q),
    .empty_i(empty),
    .head_i (head),
    .pop_o  (pop),
    .out_valid_o,
    .out_ready_i,
    .cell_column_o,
    .cell_row_o,
    .char_code_o,
    .define_glyph_o,
    .glyph_bits_o,
    .last_cell_o
  );

endmodule

// ===== src/clbgr_checker.sv =====
module clbgr_checker import clbgr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [6:0]  cell_column_o,
  input logic [1:0]  cell_row_o,
  input logic [7:0]  char_code_o,
  input logic        define_glyph_o,
  input logic [39:0] glyph_bits_o,
  input logic        last_cell_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_column_o)
      && $stable(cell_row_o) && $stable(char_code_o) && $stable(define_glyph_o)
      && $stable(glyph_bits_o) && $stable(last_cell_o))
    else $error("output beat changed while stalled");

  // a generated glyph always lands in one of the eight CGRAM slots
  a_def_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && define_glyph_o |-> char_code_o[7:3] == 5'd0)
    else $error("glyph load to a code outside the slot range");

  a_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !define_glyph_o |-> glyph_bits_o == 40'd0)
    else $error("glyph bits set without a glyph load");

  // plain writes are either a frame slot or the full block
  a_plain_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !define_glyph_o |-> char_code_o == FULL_BLOCK || char_code_o[7:3] == 5'd0)
    else $error("unexpected character code");

endmodule

bind char_lcd_bar_graph_renderer clbgr_checker u_clbgr_checker (.*);

// ===== verif/tb_char_lcd_bar_graph_renderer.sv =====
module tb_char_lcd_bar_graph_renderer;
  timeunit 1ns;
  timeprecision 1ps;

  import clbgr_pkg::*;

  localparam int unsigned MAX_CELLS     = 20;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          WATCHDOG_MAX  = 3000;
  localparam int          ITEMS_PER_SET = 52;
  localparam int          NUM_DIRECTED  = 24;

  localparam logic [1:0] CFG_SPARE = 2'd3;     // unmapped index, writes are dropped
  localparam logic [7:0] CODE_FULL = 8'hFF;

  localparam logic [39:0] BAR_SINGLE    = {5'h1F, {6{5'h11}}, 5'h1F};
  localparam logic [39:0] BAR_START     = {5'h1F, {6{5'h10}}, 5'h1F};
  localparam logic [39:0] BAR_END       = {5'h1F, {6{5'h01}}, 5'h1F};
  localparam logic [39:0] BAR_MIDDLE    = {5'h1F, {6{5'h00}}, 5'h1F};
  localparam logic [39:0] BAR_OVERFLOW  = {5'h1F, 5'h0B, 5'h15, 5'h1A, 5'h1A, 5'h15, 5'h0B,
                                           5'h1F};
  localparam logic [39:0] BAR_UNDERFLOW = {5'h00, 5'h05, 5'h0A, 5'h14, 5'h14, 5'h0A, 5'h05,
                                           5'h00};

  typedef struct packed {
    logic [SlotW-1:0]       slot;
    logic [ColW-1:0]        col;
    logic [RowW-1:0]        row;
    logic [LenW-1:0]        len;
    logic signed [PctW-1:0] pct;
  } bar_req_t;

  typedef struct packed {
    logic [6:0]  column;
    logic [1:0]  row;
    logic [7:0]  code;
    logic        def;
    logic [39:0] bits;
    logic        last;
  } cell_t;

  // typed rows are single-cell bars whose result is known by inspection
  typedef struct packed {
    bar_req_t    req;
    logic        typed;
    logic [7:0]  code;
    logic        def;
    logic [39:0] bits;
  } dir_row_t;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{3'd5, 6'd0,  2'd0, 5'd1,  18'sd0},       1'b1, 8'd5,      1'b1, BAR_SINGLE},
    '{'{3'd3, 6'd63, 2'd3, 5'd1,  18'sd10000},   1'b1, CODE_FULL, 1'b0, 40'd0},
    '{'{3'd7, 6'd10, 2'd1, 5'd1,  18'sd20000},   1'b1, 8'd7,      1'b1, BAR_OVERFLOW},
    '{'{3'd0, 6'd20, 2'd2, 5'd1, -18'sd10000},   1'b1, 8'd0,      1'b1, BAR_UNDERFLOW},
    '{'{3'd6, 6'd1,  2'd0, 5'd1,  18'sd131071},  1'b1, 8'd6,      1'b1, BAR_OVERFLOW},
    '{'{3'd1, 6'd2,  2'd3, 5'd1, -18'sd131072},  1'b1, 8'd1,      1'b1, BAR_UNDERFLOW},
    '{'{3'd4, 6'd3,  2'd1, 5'd1,  18'sd1},       1'b1, 8'd4,      1'b1, BAR_SINGLE},
    '{'{3'd2, 6'd0,  2'd0, 5'd0,  18'sd20000},   1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd3, 6'd4,  2'd0, 5'd2,  18'sd0},       1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd3, 6'd5,  2'd1, 5'd3,  18'sd0},       1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd7, 6'd0,  2'd2, 5'd20, 18'sd10000},   1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd6, 6'd44, 2'd3, 5'd20, 18'sd20000},   1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd5, 6'd0,  2'd0, 5'd20, -18'sd10000},  1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd2, 6'd63, 2'd3, 5'd31, 18'sd5000},    1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd1, 6'd8,  2'd1, 5'd5,  18'sd3333},    1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd0, 6'd9,  2'd2, 5'd1,  18'sd3334},    1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd4, 6'd10, 2'd3, 5'd2,  18'sd100},     1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd3, 6'd11, 2'd0, 5'd4,  -18'sd1},      1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd7, 6'd12, 2'd1, 5'd8,  18'sd9999},    1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd6, 6'd63, 2'd2, 5'd16, -18'sd5000},   1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd5, 6'd32, 2'd1, 5'd20, 18'sd100000},  1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd2, 6'd13, 2'd0, 5'd7,  18'sd20001},   1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd1, 6'd14, 2'd3, 5'd9,  -18'sd10001},  1'b0, 8'd0,      1'b0, 40'd0},
    '{'{3'd0, 6'd15, 2'd0, 5'd21, 18'sd15000},   1'b0, 8'd0,      1'b0, 40'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_idx = CFG_START;
  logic [SlotW-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SlotW-1:0]       glyph_slot = '0;
  logic [ColW-1:0]        pos_col = '0;
  logic [RowW-1:0]        pos_row = '0;
  logic [LenW-1:0]        bar_length = '0;
  logic signed [PctW-1:0] percent_hundredths = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [6:0]             cell_column;
  logic [1:0]             cell_row;
  logic [7:0]             char_code;
  logic                   define_glyph;
  logic [39:0]            glyph_bits;
  logic                   last_cell;

  logic [SlotW-1:0] slot_start  = 3'd0;
  logic [SlotW-1:0] slot_middle = 3'd1;
  logic [SlotW-1:0] slot_end    = 3'd2;

  cell_t expected_cells[$];
  int    field_errors = 0;
  int    rx_hold_cycles = 0;
  bit    no_gaps = 1'b0;

  char_lcd_bar_graph_renderer #(
    .MAX_CELLS(MAX_CELLS)
  ) u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .glyph_slot_i        (glyph_slot),
    .pos_col_i           (pos_col),
    .pos_row_i           (pos_row),
    .bar_length_i        (bar_length),
    .percent_hundredths_i(percent_hundredths),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .cell_column_o       (cell_column),
    .cell_row_o          (cell_row),
    .char_code_o         (char_code),
    .define_glyph_o      (define_glyph),
    .glyph_bits_o        (glyph_bits),
    .last_cell_o         (last_cell)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Expected cells of one bar, appended to expected_cells.
  function automatic void predict_bar(bar_req_t r);
    int    len;
    int    p;
    int    fill;
    int    cap;
    int    stop;
    int    dc;
    bit    first;
    bit    last;
    cell_t c;

    len = (r.len > MAX_CELLS) ? MAX_CELLS : int'(r.len);
    if (len == 0) return;
    p = $signed(r.pct);
    if (p < -10000) p = -10000;
    if (p > 20000) p = 20000;
    fill = (5 * len - 2) * p / 10000;

    for (int n = 0; n < len; n++) begin
      first = (n == 0);
      last = (n == len - 1);
      cap = 5 - int'(first) - int'(last);
      c.column = 7'(r.col) + 7'(n);
      c.row = r.row;
      c.last = last;
      c.def = 1'b0;
      c.bits = '0;
      c.code = 8'(r.slot);
      if (fill == 0) begin
        if (first && last) begin
          c.def = 1'b1;
          c.bits = BAR_SINGLE;
        end else if (first) begin
          c.code = 8'(slot_start);
        end else if (last) begin
          c.code = 8'(slot_end);
        end else begin
          c.code = 8'(slot_middle);
        end
      end else if (fill >= cap) begin
        fill -= cap;
        if (fill > 0 && last) begin
          c.def = 1'b1;
          c.bits = BAR_OVERFLOW;
        end else begin
          c.code = CODE_FULL;
        end
      end else if (fill < 0 && first) begin
        fill = 0;
        c.def = 1'b1;
        c.bits = BAR_UNDERFLOW;
      end else begin
        c.def = 1'b1;
        c.bits = (first && last) ? BAR_SINGLE : first ? BAR_START :
                 last ? BAR_END : BAR_MIDDLE;
        stop = last ? 4 : 5;
        // each dot column fills rows 1..6
        for (dc = int'(first); dc < stop && fill > 0; dc++) begin
          for (int rr = 1; rr < 7; rr++) c.bits[39 - 5 * rr - dc] = 1'b1;
          fill--;
        end
      end
      expected_cells.push_back(c);
    end
  endfunction

  function automatic bar_req_t random_bar();
    bar_req_t r;
    int       v;

    r.slot = SlotW'($urandom);
    r.col = ColW'($urandom);
    r.row = RowW'($urandom);
    case ($urandom_range(0, 9))
      0:       r.len = 5'd0;
      1:       r.len = LenW'($urandom_range(21, 31));
      2, 3, 4: r.len = LenW'($urandom_range(1, 4));
      default: r.len = LenW'($urandom_range(1, 20));
    endcase
    case ($urandom_range(0, 9))
      6: begin
        case ($urandom_range(0, 5))
          0:       v = -10000;
          1:       v = -10001;
          2:       v = 20000;
          3:       v = 20001;
          4:       v = 0;
          default: v = 10000;
        endcase
        r.pct = v[PctW-1:0];
      end
      7, 8, 9: r.pct = PctW'($urandom);
      default: begin
        v = int'($urandom_range(0, 30000)) - 10000;
        r.pct = v[PctW-1:0];
      end
    endcase
    return r;
  endfunction

  // Leaves valid high on return; the next call or the caller drops it.
  task automatic send_bar(bar_req_t r, bit typed, cell_t typed_cell);
    int gap;

    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    glyph_slot <= r.slot;
    pos_col <= r.col;
    pos_row <= r.row;
    bar_length <= r.len;
    percent_hundredths <= r.pct;
    do @(posedge clk); while (!in_ready);
    if (typed) expected_cells.push_back(typed_cell);
    else predict_bar(r);
  endtask

  task automatic set_slots(logic [SlotW-1:0] s, logic [SlotW-1:0] m, logic [SlotW-1:0] e);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_START;
    cfg_data <= s;
    @(posedge clk);
    slot_start = s;
    cfg_idx <= CFG_MIDDLE;
    cfg_data <= m;
    @(posedge clk);
    slot_middle = m;
    cfg_idx <= CFG_END;
    cfg_data <= e;
    @(posedge clk);
    slot_end = e;
    cfg_idx <= CFG_SPARE;
    cfg_data <= SlotW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    cell_t    tc;
    bar_req_t r;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed bars under reset slot values
    foreach (directed_rows[i]) begin
      tc.column = 7'(directed_rows[i].req.col);
      tc.row = directed_rows[i].req.row;
      tc.code = directed_rows[i].code;
      tc.def = directed_rows[i].def;
      tc.bits = directed_rows[i].bits;
      tc.last = 1'b1;
      send_bar(directed_rows[i].req, directed_rows[i].typed, tc);
    end
    in_valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_slots(3'd7, 3'd7, 3'd7);
        1:       set_slots(3'd0, 3'd0, 3'd0);
        default: set_slots(SlotW'($urandom), SlotW'($urandom), SlotW'($urandom));
      endcase
      no_gaps = (phase == 1);
      // receiver stalls while bars keep coming in, so the input backs up
      if (phase == 2) rx_hold_cycles = HOLD_CYCLES;
      for (int k = 0; k < ITEMS_PER_SET; k++) begin
        r = random_bar();
        send_bar(r, 1'b0, tc);
        if (phase == 3 && k == ITEMS_PER_SET / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (expected_cells.size() != 0);
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    if (field_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int wait_cycles;

    forever begin
      if (rx_hold_cycles > 0) begin
        wait_cycles = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        wait_cycles = no_gaps ? 0 : $urandom_range(0, 10);
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_field(string what, logic [39:0] want, logic [39:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      field_errors++;
    end
  endfunction

  always @(posedge clk) begin
    cell_t want;

    if (rst_n && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected beat, expected none got col %0d row %0d code %h def %b",
                 $time, cell_column, cell_row, char_code, define_glyph);
        field_errors++;
      end else begin
        want = expected_cells.pop_front();
        check_field("cell_column", 40'(want.column), 40'(cell_column));
        check_field("cell_row", 40'(want.row), 40'(cell_row));
        check_field("char_code", 40'(want.code), 40'(char_code));
        check_field("define_glyph", 40'(want.def), 40'(define_glyph));
        check_field("glyph_bits", want.bits, glyph_bits);
        check_field("last_cell", 40'(want.last), 40'(last_cell));
      end
    end
  end

  // watchdog: cycles in a row with no beat on either side
  initial begin
    int idle_cycles;

    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_MAX) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no beat for %0d cycles", $time, WATCHDOG_MAX);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
